// ===== rtl/clre_pkg.sv =====
// ----------------------------------------------------------------------------
// clre_pkg: shared types and constants of the colour register encoder
// Configuration struct, field layouts, register indexes and arithmetic
// constants used by all pipeline stages.
// ----------------------------------------------------------------------------
package clre_pkg;

  localparam int unsigned LevelW         = 16;
  localparam int unsigned ChanW          = 8;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned WordW          = 32;
  localparam int unsigned LumaW          = 24;
  localparam int unsigned IndexLimit     = 256;
  localparam int unsigned PaletteEntries = 16;
  localparam int unsigned LumaR          = 77;
  localparam int unsigned LumaG          = 151;
  localparam int unsigned LumaB          = 28;
  localparam int unsigned RoundBias      = 32'h7FFF;
  localparam int unsigned CfgDataW       = 3;
  localparam int unsigned CfgIndexW      = 2;
  // Width of the rounding sum: a level scaled by up to 2^8 plus one guard bit.
  localparam int unsigned AccW           = LevelW + ChanW + 1;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    REG_PIXEL_DEPTH    = 2'd0,
    REG_ALPHA_LAYOUT   = 2'd1,
    REG_VISUAL_KIND    = 2'd2,
    REG_GRAYSCALE_MODE = 2'd3
  } reg_idx_e;

  // Pixel depth codes; codes above DEPTH_32 behave as DEPTH_32.
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_8  = 3'd1;
  localparam logic [2:0] DEPTH_16 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  localparam logic [1:0] VISUAL_TRUECOLOR = 2'd0;

  typedef struct packed {
    logic [2:0] pixel_depth;
    logic       alpha_layout;
    logic [1:0] visual_kind;
    logic       grayscale_mode;
  } cfg_t;

  // Field widths and offsets, channel order red, green, blue, alpha.
  typedef struct packed {
    logic [3:0][3:0] wid;
    logic [3:0][4:0] off;
  } layout_t;

  typedef struct packed {
    logic                        status;
    logic                        write;
    logic [SlotW-1:0]            slot;
    logic [3:0][LevelW-1:0]      level;
  } luma_stage_t;

  typedef struct packed {
    logic                        status;
    logic                        write;
    logic [SlotW-1:0]            slot;
    logic [3:0][ChanW-1:0]       chan;
  } round_stage_t;

  function automatic layout_t pick_layout(cfg_t cfg);
    layout_t l;
    l = '0;
    if (cfg.pixel_depth <= DEPTH_8) begin
      l.wid[0] = 4'd8;
      l.wid[1] = 4'd8;
      l.wid[2] = 4'd8;
    end else if (cfg.pixel_depth == DEPTH_16) begin
      l.wid[0] = 4'd5;
      l.off[1] = 5'd5;
      l.wid[2] = 4'd5;
      if (cfg.alpha_layout) begin
        l.wid[1] = 4'd5;
        l.off[2] = 5'd10;
        l.wid[3] = 4'd1;
        l.off[3] = 5'd15;
      end else begin
        l.wid[1] = 4'd6;
        l.off[2] = 5'd11;
      end
    end else begin
      l.wid[0] = 4'd8;
      l.wid[1] = 4'd8;
      l.off[1] = 5'd8;
      l.wid[2] = 4'd8;
      l.off[2] = 5'd16;
      if (cfg.pixel_depth != DEPTH_24) begin
        l.wid[3] = 4'd8;
        l.off[3] = 5'd24;
      end
    end
    return l;
  endfunction

endpackage

// ===== rtl/clre_if.sv =====
// ----------------------------------------------------------------------------
// clre_if: request and result channels of the colour register encoder
// Valid/ready channels carrying one colour-register write and one result.
// ----------------------------------------------------------------------------
interface clre_req_if;
  import clre_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] entry_index;
  logic [LevelW-1:0] red_level;
  logic [LevelW-1:0] green_level;
  logic [LevelW-1:0] blue_level;
  logic [LevelW-1:0] alpha_level;

  modport source (output valid, entry_index, red_level, green_level, blue_level,
                  alpha_level, input ready);
  modport sink (input valid, entry_index, red_level, green_level, blue_level,
                alpha_level, output ready);
endinterface

interface clre_rsp_if;
  import clre_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic             palette_write;
  logic [SlotW-1:0] palette_slot;
  logic [WordW-1:0] palette_word;

  modport source (output valid, status, palette_write, palette_slot, palette_word,
                  input ready);
  modport sink (input valid, status, palette_write, palette_slot, palette_word,
                output ready);
endinterface

// ===== rtl/clre_luma.sv =====
// ----------------------------------------------------------------------------
// clre_luma: first pipeline stage
// Classifies the entry index and applies the optional grayscale weighting.
// ----------------------------------------------------------------------------
module clre_luma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clre_pkg::cfg_t       cfg_i,
  clre_req_if.sink             req_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output clre_pkg::luma_stage_t data_o
);
  import clre_pkg::*;

  logic        valid_q;
  luma_stage_t data_q, data_d;
  logic [LumaW-1:0] luma_sum;
  logic [LevelW-1:0] luma;

  assign req_i.ready = !valid_q || ready_i;

  // Weighted sum fits in 24 bits since the weights add up to 256.
  assign luma_sum = {8'd0, req_i.red_level}   * LumaW'(LumaR)
                  + {8'd0, req_i.green_level} * LumaW'(LumaG)
                  + {8'd0, req_i.blue_level}  * LumaW'(LumaB);
  assign luma = luma_sum[LumaW-1:LumaW-LevelW];

  always_comb begin
    data_d        = '0;
    data_d.status = 1'b0;
    data_d.write  = 1'b0;
    if (req_i.entry_index >= LevelW'(IndexLimit)) begin
      data_d.status = 1'b1;
    end else if (cfg_i.visual_kind != VISUAL_TRUECOLOR) begin
      data_d.status = 1'b0;
    end else if (req_i.entry_index >= LevelW'(PaletteEntries)) begin
      data_d.status = 1'b1;
    end else begin
      data_d.write = (cfg_i.pixel_depth >= DEPTH_16);
    end
    data_d.slot = data_d.write ? req_i.entry_index[SlotW-1:0] : '0;
    if (cfg_i.grayscale_mode) begin
      data_d.level[0] = luma;
      data_d.level[1] = luma;
      data_d.level[2] = luma;
    end else begin
      data_d.level[0] = req_i.red_level;
      data_d.level[1] = req_i.green_level;
      data_d.level[2] = req_i.blue_level;
    end
    data_d.level[3] = req_i.alpha_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/clre_round.sv =====
// ----------------------------------------------------------------------------
// clre_round: second pipeline stage
// Rounds each 16-bit level to the field width of the active layout.
// ----------------------------------------------------------------------------
module clre_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clre_pkg::cfg_t         cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  clre_pkg::luma_stage_t  data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output clre_pkg::round_stage_t data_o
);
  import clre_pkg::*;

  logic         valid_q;
  round_stage_t data_q, data_d;
  layout_t      layout;
  logic [3:0][AccW-1:0] acc;

  assign layout  = pick_layout(cfg_i);
  assign ready_o = !valid_q || ready_i;

  // v * (2^w - 1) + 0x7FFF stays below 2^(16 + w), so the top bits fit the field.
  always_comb begin
    data_d.status = data_i.status;
    data_d.write  = data_i.write;
    data_d.slot   = data_i.slot;
    for (int i = 0; i < 4; i++) begin
      acc[i] = (AccW'(data_i.level[i]) << layout.wid[i]) - AccW'(data_i.level[i])
             + AccW'(RoundBias);
      data_d.chan[i] = acc[i][LevelW+ChanW-1:LevelW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/clre_pack.sv =====
// ----------------------------------------------------------------------------
// clre_pack: third pipeline stage and output register
// Places the rounded channels at their offsets and forms the result word.
// ----------------------------------------------------------------------------
module clre_pack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clre_pkg::cfg_t         cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  clre_pkg::round_stage_t data_i,
  clre_rsp_if.source             rsp_o
);
  import clre_pkg::*;

  logic             valid_q;
  logic             status_q;
  logic             write_q;
  logic [SlotW-1:0] slot_q;
  logic [WordW-1:0] word_q, word_d;
  layout_t          layout;

  assign layout  = pick_layout(cfg_i);
  assign ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    word_d = '0;
    for (int i = 0; i < 4; i++) begin
      word_d = word_d | (WordW'(data_i.chan[i]) << layout.off[i]);
    end
    if (!data_i.write) begin
      word_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      status_q <= data_i.status;
      write_q  <= data_i.write;
      slot_q   <= data_i.slot;
      word_q   <= word_d;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.palette_write = write_q;
  assign rsp_o.palette_slot  = slot_q;
  assign rsp_o.palette_word  = word_q;

endmodule

// ===== rtl/colour_register_encode.sv =====
// ----------------------------------------------------------------------------
// colour_register_encode: truecolor pseudo-palette encoder
// Turns one colour-register write into a status and an optional packed
// pseudo-palette word, in a three-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result side takes words;
// results leave through the output register. The three register stages
// are the grayscale weighting with index check, the rounding of each channel
// to its field width, and the packing into the output register. Each stage
// holds one word and carries its own valid bit; the ready of the request side
// is the output ready passed back through the stages, so a full pipeline keeps
// accepting as long as the result side keeps taking words. Configuration is
// written through the plain write port and must only change while no word is
// in flight.
// ----------------------------------------------------------------------------
module colour_register_encode (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [clre_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [clre_pkg::CfgDataW-1:0]      cfg_data_i,
  clre_req_if.sink                           req_i,
  clre_rsp_if.source                         rsp_o
);
  import clre_pkg::*;

  cfg_t         cfg_q;
  logic         s1_valid, s1_ready;
  luma_stage_t  s1_data;
  logic         s2_valid, s2_ready;
  round_stage_t s2_data;

  // Configuration registers, loaded whenever the write enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_depth    <= DEPTH_16;
      cfg_q.alpha_layout   <= 1'b0;
      cfg_q.visual_kind    <= VISUAL_TRUECOLOR;
      cfg_q.grayscale_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PIXEL_DEPTH:    cfg_q.pixel_depth    <= cfg_data_i;
        REG_ALPHA_LAYOUT:   cfg_q.alpha_layout   <= cfg_data_i[0];
        REG_VISUAL_KIND:    cfg_q.visual_kind    <= cfg_data_i[1:0];
        REG_GRAYSCALE_MODE: cfg_q.grayscale_mode <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: index classification and grayscale weighting.
  clre_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .req_i   (req_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage two: rounding of each channel to its field width.
  clre_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stage three: packing into the output register.
  clre_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .rsp_o   (rsp_o)
  );

`ifndef ASSERT_OFF
  // A stored palette word always comes with an accepted status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.palette_write |-> !rsp_o.status)
    else $error("palette write reported with error status");

  // Without a palette write the slot and word are cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.palette_write |-> rsp_o.palette_slot == '0 &&
                                            rsp_o.palette_word == '0)
    else $error("slot or word set on a result without palette write");

  // The request side only stalls when the result side holds back a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("request stalled while the result side is free");
`endif

endmodule
